// ===== rtl/line_camera_exposure_and_edge_level_defines.svh =====
// assertion macros for the line camera exposure and edge level block
// expects clk_i and rst_ni in the scope of each use; no other dependencies
`ifndef LINE_CAMERA_EXPOSURE_AND_EDGE_LEVEL_DEFINES_SVH
`define LINE_CAMERA_EXPOSURE_AND_EDGE_LEVEL_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LCEL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define LCEL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lcel_pkg.sv =====
// shared widths, constants, register codes and the white level helper
// for the line camera exposure and edge level block; no dependencies
`default_nettype none

package lcel_pkg;

  // line geometry
  localparam int LinePixels = 128;
  localparam int PosW       = $clog2(LinePixels);
  localparam logic [PosW-1:0] LastPos = PosW'(LinePixels - 1);

  // field widths
  localparam int SampleW  = 12;
  localparam int PixW     = 8;
  localparam int ExpW     = 10;
  localparam int SumW     = 10;
  localparam int EdgeW    = 7;
  localparam int CntW     = 8;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 10;

  // pixel windows
  localparam logic [PosW-1:0] CenterFirst = PosW'(62);
  localparam logic [PosW-1:0] CenterLast  = PosW'(65);
  localparam logic [PosW-1:0] StepFirst   = PosW'(2);
  localparam logic [PosW-1:0] StepLast    = PosW'(65);
  localparam logic [PosW-1:0] DefaultPos  = PosW'(64);
  localparam logic [EdgeW-1:0] DefaultEdge = EdgeW'(64);

  // exposure steps and limits
  localparam logic [ExpW-1:0] ExpReset = ExpW'(300);
  localparam logic [ExpW-1:0] ExpUp    = ExpW'(10);
  localparam logic [ExpW-1:0] ExpDown  = ExpW'(9);
  localparam logic [ExpW:0]   ExpCeil  = (ExpW+1)'(1023);

  // register defaults
  localparam logic [PixW-1:0] TargetLowReset  = PixW'(57);
  localparam logic [PixW-1:0] TargetHighReset = PixW'(59);
  localparam logic [ExpW-1:0] ExpMinReset     = ExpW'(140);
  localparam logic [ExpW-1:0] ExpMaxReset     = ExpW'(500);
  localparam logic [CntW-1:0] StartupReset    = CntW'(200);
  localparam logic [CntW-1:0] GapReset        = CntW'(20);

  // white level
  localparam logic [PixW:0] WhiteMin  = (PixW+1)'(10);
  localparam logic [PixW:0] WhiteSat  = (PixW+1)'(255);
  localparam logic [15:0]   TenthMul  = 16'd205;
  localparam int            TenthShift = 11;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgInitialExposure = 3'd0,
    CfgTargetLow       = 3'd1,
    CfgTargetHigh      = 3'd2,
    CfgExposureMin     = 3'd3,
    CfgExposureMax     = 3'd4,
    CfgStartupFrames   = 3'd5,
    CfgCheckGap        = 3'd6
  } cfg_idx_e;

  // p + p/10 + 1, saturated at 255, zero below 10; p/10 as (p*205)>>11
  function automatic logic [PixW-1:0] white_from(input logic [PixW-1:0] p);
    logic [15:0]     prod;
    logic [PixW-1:0] tenth;
    logic [PixW:0]   sum;
    prod  = 16'(p) * TenthMul;
    tenth = PixW'(prod >> TenthShift);
    sum   = (PixW+1)'(p) + (PixW+1)'(tenth) + (PixW+1)'(1);
    if (sum > WhiteSat) begin
      sum = WhiteSat;
    end
    if (sum < WhiteMin) begin
      sum = '0;
    end
    return sum[PixW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lcel_intf.sv =====
// channel interfaces: pixel input, line result output and register writes
// depends on lcel_pkg for the field widths
`default_nettype none

// pixel sample channel
interface lcel_in_if import lcel_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] sample;
  logic               line_end;

  modport source (output valid, output sample, output line_end, input ready);
  modport sink   (input valid, input sample, input line_end, output ready);
endinterface

// per-line result channel
interface lcel_out_if import lcel_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ExpW-1:0]  exposure;
  logic             calibrated;
  logic [PixW-1:0]  center_average;
  logic [PixW-1:0]  white_level;
  logic             white_valid;
  logic [EdgeW-1:0] edge_position;

  modport source (output valid, output exposure, output calibrated, output center_average,
                  output white_level, output white_valid, output edge_position,
                  input ready);
  modport sink   (input valid, input exposure, input calibrated, input center_average,
                  input white_level, input white_valid, input edge_position,
                  output ready);
endinterface

// register write channel
interface lcel_cfg_if import lcel_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/line_camera_exposure_and_edge_level.sv =====
// A result is registered after the transfer of its line-end sample, first in the sample
// register, then in the result register. Throughput: one sample per cycle, set by the
// single per-pixel pass of subtract, compare and add, while no held result stalls input.
// A held result stalls input only once a second line end reaches the sample stage.
// Reset (async, active low) clears line and exposure state, loads exposure 300
// and restores all configuration registers to their defaults; no clearing pass is needed.
`default_nettype none
`include "line_camera_exposure_and_edge_level_defines.svh"

module line_camera_exposure_and_edge_level import lcel_pkg::*; (
  input  wire          clk_i,
  input  wire          rst_ni,
  lcel_in_if.sink      pix_i,
  lcel_cfg_if.sink     cfg_i,
  lcel_out_if.source   res_o
);

  // configuration registers
  logic [PixW-1:0] target_low_q, target_high_q;
  logic [ExpW-1:0] exp_min_q, exp_max_q;
  logic [CntW-1:0] startup_frames_q, check_gap_q;

  // sample stage
  logic               s_valid_q;
  logic [SampleW-1:0] s_sample_q;
  logic               s_last_q;

  // per-line state
  logic [PosW-1:0]  pos_q, pos_d;
  logic [PixW-1:0]  prev_q, prev_d;
  logic [SumW-1:0]  sum_q, sum_d;
  logic [PixW-1:0]  best_step_q, best_step_d;
  logic [EdgeW-1:0] best_pos_q, best_pos_d;
  logic [PixW-1:0]  best_low_q, best_low_d;

  // exposure state
  logic [ExpW-1:0] exp_q, exp_d;
  logic [CntW-1:0] lines_q, lines_d;
  logic [CntW-1:0] startup_q, startup_d;
  logic            cal_q, cal_d;
  logic            wdone_q, wdone_d;
  logic [PixW-1:0] white_q, white_d;

  // result register
  logic             out_valid_q;
  logic [ExpW-1:0]  out_exp_q;
  logic             out_cal_q;
  logic [PixW-1:0]  out_avg_q;
  logic [PixW-1:0]  out_white_q;
  logic             out_wvalid_q;
  logic [EdgeW-1:0] out_edge_q;

  // handshake
  logic out_free, advance, in_ready, held_end;

  assign out_free = !out_valid_q || res_o.ready;
  assign advance  = s_valid_q && (!s_last_q || out_free);
  assign in_ready = !s_valid_q || advance;
  assign held_end = s_valid_q && s_last_q;
  assign pix_i.ready = in_ready;
  assign cfg_i.ready = 1'b1;

  // combinational per-sample pass
  logic [PixW-1:0]  pix, diff;
  logic [PixW-1:0]  avg;
  logic [ExpW:0]    exp_up_sum;
  logic             step_hit, check_run, in_range;

  always_comb begin
    pix         = s_sample_q[SampleW-1 -: PixW];
    pos_d       = pos_q;
    prev_d      = pix;
    sum_d       = sum_q;
    best_step_d = best_step_q;
    best_pos_d  = best_pos_q;
    best_low_d  = best_low_q;
    exp_d       = exp_q;
    lines_d     = lines_q;
    startup_d   = startup_q;
    cal_d       = cal_q;
    wdone_d     = wdone_q;
    white_d     = white_q;

    // center sum
    if (pos_q >= CenterFirst && pos_q <= CenterLast) begin
      sum_d = sum_q + SumW'(pix);
    end

    // strongest rising step, ties to the higher index
    diff     = pix - prev_q;
    step_hit = (pos_q >= StepFirst) && (pos_q <= StepLast) && (pix > prev_q);
    if (step_hit && diff >= best_step_q) begin
      best_step_d = diff;
      best_pos_d  = EdgeW'(pos_q - PosW'(1));
      best_low_d  = prev_q;
    end
    if (pos_q == DefaultPos && best_step_d == '0) begin
      best_low_d = pix;
    end

    // position holds at the last pixel of a long line
    if (pos_q < LastPos) begin
      pos_d = pos_q + PosW'(1);
    end

    // line end: exposure check, white level, counters
    avg        = sum_d[SumW-1 -: PixW];
    check_run  = !cal_q && (lines_q > check_gap_q) && (startup_q == startup_frames_q);
    in_range   = (exp_q >= exp_min_q) && (exp_q <= exp_max_q);
    exp_up_sum = (ExpW+1)'(exp_q) + (ExpW+1)'(ExpUp);
    if (s_last_q) begin
      if (check_run) begin
        if (avg < target_low_q) begin
          if (exp_q < exp_max_q) begin
            exp_d = (exp_up_sum > ExpCeil) ? ExpCeil[ExpW-1:0] : exp_up_sum[ExpW-1:0];
          end
        end else if (avg > target_high_q && in_range) begin
          if (exp_q > exp_min_q) begin
            exp_d = (exp_q < ExpDown) ? '0 : exp_q - ExpDown;
          end
        end else begin
          cal_d = 1'b1;
        end
      end
      if (cal_d && !wdone_q) begin
        white_d = white_from(best_low_d);
        wdone_d = 1'b1;
      end
      lines_d = check_run ? CntW'(1) : lines_q + CntW'(1);
      if (startup_q != startup_frames_q) begin
        startup_d = startup_q + CntW'(1);
      end
    end
  end

  // register writes; initial exposure writes are ignored, reset loads exposure 300
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_low_q     <= TargetLowReset;
      target_high_q    <= TargetHighReset;
      exp_min_q        <= ExpMinReset;
      exp_max_q        <= ExpMaxReset;
      startup_frames_q <= StartupReset;
      check_gap_q      <= GapReset;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CfgTargetLow:     target_low_q     <= cfg_i.data[PixW-1:0];
        CfgTargetHigh:    target_high_q    <= cfg_i.data[PixW-1:0];
        CfgExposureMin:   exp_min_q        <= cfg_i.data[ExpW-1:0];
        CfgExposureMax:   exp_max_q        <= cfg_i.data[ExpW-1:0];
        CfgStartupFrames: startup_frames_q <= cfg_i.data[CntW-1:0];
        CfgCheckGap:      check_gap_q      <= cfg_i.data[CntW-1:0];
        default: ;
      endcase
    end
  end

  // sample stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (in_ready) begin
      s_valid_q <= pix_i.valid;
    end
  end

  // sample stage payload
  always_ff @(posedge clk_i) begin
    if (in_ready && pix_i.valid) begin
      s_sample_q <= pix_i.sample;
      s_last_q   <= pix_i.line_end;
    end
  end

  // line and exposure state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      prev_q      <= '0;
      sum_q       <= '0;
      best_step_q <= '0;
      best_pos_q  <= DefaultEdge;
      best_low_q  <= '0;
      exp_q       <= ExpReset;
      lines_q     <= '0;
      startup_q   <= '0;
      cal_q       <= 1'b0;
      wdone_q     <= 1'b0;
      white_q     <= '0;
    end else if (advance) begin
      exp_q     <= exp_d;
      lines_q   <= lines_d;
      startup_q <= startup_d;
      cal_q     <= cal_d;
      wdone_q   <= wdone_d;
      white_q   <= white_d;
      if (s_last_q) begin
        pos_q       <= '0;
        prev_q      <= '0;
        sum_q       <= '0;
        best_step_q <= '0;
        best_pos_q  <= DefaultEdge;
        best_low_q  <= '0;
      end else begin
        pos_q       <= pos_d;
        prev_q      <= prev_d;
        sum_q       <= sum_d;
        best_step_q <= best_step_d;
        best_pos_q  <= best_pos_d;
        best_low_q  <= best_low_d;
      end
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && s_last_q) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (advance && s_last_q) begin
      out_exp_q    <= exp_d;
      out_cal_q    <= cal_d;
      out_avg_q    <= avg;
      out_white_q  <= white_d;
      out_wvalid_q <= wdone_d;
      out_edge_q   <= best_pos_d;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.exposure       = out_exp_q;
  assign res_o.calibrated     = out_cal_q;
  assign res_o.center_average = out_avg_q;
  assign res_o.white_level    = out_white_q;
  assign res_o.white_valid    = out_wvalid_q;
  assign res_o.edge_position  = out_edge_q;

  // checks
  `LCEL_ASSERT_NEXT(a_exp_frozen, cal_q, exp_q == $past(exp_q), "exposure moved after calibration")
  `LCEL_ASSERT_SAME(a_white_needs_cal, wdone_q, cal_q, "white level done without calibration")
  `LCEL_ASSERT_SAME(a_white_unset_zero, !wdone_q, white_q == '0, "white level set before done")
  `LCEL_ASSERT_SAME(a_pos_bound, 1'b1, pos_q <= LastPos, "pixel position past line length")
  `LCEL_ASSERT_NEXT(a_line_end_held, held_end && !out_free, held_end, "line end dropped")
  `LCEL_ASSERT_NEXT(a_result_loaded, advance && s_last_q, out_valid_q, "line end gave no result")

endmodule

`default_nettype wire

// ===== test/line_camera_exposure_and_edge_level_check.sv =====
// line result checker: watches the pixel, register and result channels,
// predicts each line result and compares it; depends on lcel_pkg and lcel_intf
module line_camera_exposure_and_edge_level_check import lcel_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  lcel_in_if   pix_i,
  lcel_cfg_if  cfg_i,
  lcel_out_if  res_i,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    logic [ExpW-1:0]  exposure;
    logic             calibrated;
    logic [PixW-1:0]  center_average;
    logic [PixW-1:0]  white_level;
    logic             white_valid;
    logic [EdgeW-1:0] edge_position;
  } line_result_t;

  line_result_t expected_lines[$];

  // register copies
  logic [ExpW-1:0] reg_initial_exposure;
  logic [PixW-1:0] reg_target_low;
  logic [PixW-1:0] reg_target_high;
  logic [ExpW-1:0] reg_exposure_min;
  logic [ExpW-1:0] reg_exposure_max;
  logic [CntW-1:0] reg_startup_frames;
  logic [CntW-1:0] reg_check_gap;

  // per-line statistics
  logic [7:0]       line_pos;
  logic [PixW-1:0]  prev_pix;
  logic [SumW-1:0]  center_sum;
  logic [PixW:0]    best_step;
  logic [EdgeW-1:0] best_pos;
  logic [PixW-1:0]  best_low;

  // exposure loop state
  logic [ExpW-1:0] exposure_now;
  logic [CntW-1:0] lines_since_check;
  logic [CntW-1:0] startup_count;
  logic            is_calibrated;
  logic            white_done;
  logic [PixW-1:0] white_level_q;

  task automatic clear_line_stats();
    line_pos   = '0;
    prev_pix   = '0;
    center_sum = '0;
    best_step  = '0;
    best_pos   = DefaultEdge;
    best_low   = '0;
  endtask

  // one exposure step; accepted unless avg is below target low, or above target high with exposure in range
  task automatic judge_exposure(input logic [PixW-1:0] avg, output logic accepted);
    logic            in_range;
    logic [ExpW:0]   raised;
    in_range = exposure_now >= reg_exposure_min && exposure_now <= reg_exposure_max;
    accepted = 1'b0;
    if (avg < reg_target_low) begin
      if (exposure_now < reg_exposure_max) begin
        raised = {1'b0, exposure_now} + {1'b0, ExpUp};
        exposure_now = (raised > ExpCeil) ? ExpCeil[ExpW-1:0] : raised[ExpW-1:0];
      end
    end else if (avg > reg_target_high && in_range) begin
      if (exposure_now > reg_exposure_min) begin
        exposure_now = (exposure_now < ExpDown) ? '0 : exposure_now - ExpDown;
      end
    end else begin
      accepted = 1'b1;
    end
  endtask

  // fold one pixel into the line statistics, close the line on its last pixel
  task automatic track_pixel(input logic [SampleW-1:0] sample, input logic last);
    logic [PixW-1:0] pix;
    logic [PixW:0]   rise;
    logic [PixW:0]   white_sum;
    logic [PixW-1:0] avg;
    line_result_t    res;
    pix = sample[SampleW-1 -: PixW];
    if (line_pos >= CenterFirst && line_pos <= CenterLast) begin
      center_sum = center_sum + SumW'(pix);
    end
    if (line_pos >= StepFirst && line_pos <= StepLast && pix > prev_pix) begin
      rise = {1'b0, pix} - {1'b0, prev_pix};
      if (rise >= best_step) begin
        best_step = rise;
        best_pos  = EdgeW'(line_pos - 8'd1);
        best_low  = prev_pix;
      end
    end
    if (line_pos == DefaultPos && best_step == '0) begin
      best_low = pix;
    end
    prev_pix = pix;
    if (line_pos < 8'(LinePixels - 1)) begin
      line_pos = line_pos + 8'd1;
    end
    if (last) begin
      avg = PixW'(center_sum >> 2);
      if (!is_calibrated && lines_since_check > reg_check_gap &&
          startup_count == reg_startup_frames) begin
        judge_exposure(avg, is_calibrated);
        lines_since_check = '0;
      end
      // white level is taken once, in the line that first accepts exposure
      if (is_calibrated && !white_done) begin
        white_sum = (PixW+1)'(best_low) + (PixW+1)'(best_low / 8'd10) + (PixW+1)'(1);
        if (white_sum > WhiteSat) begin
          white_sum = WhiteSat;
        end
        if (white_sum < WhiteMin) begin
          white_sum = '0;
        end
        white_level_q = white_sum[PixW-1:0];
        white_done    = 1'b1;
      end
      lines_since_check = lines_since_check + CntW'(1);
      if (startup_count != reg_startup_frames) begin
        startup_count = startup_count + CntW'(1);
      end
      res.exposure       = exposure_now;
      res.calibrated     = is_calibrated;
      res.center_average = avg;
      res.white_level    = white_level_q;
      res.white_valid    = white_done;
      res.edge_position  = best_pos;
      expected_lines.push_back(res);
      clear_line_stats();
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    line_result_t want;
    if (!rst_ni) begin
      reg_initial_exposure = ExpReset;
      reg_target_low       = TargetLowReset;
      reg_target_high      = TargetHighReset;
      reg_exposure_min     = ExpMinReset;
      reg_exposure_max     = ExpMaxReset;
      reg_startup_frames   = StartupReset;
      reg_check_gap        = GapReset;
      clear_line_stats();
      exposure_now      = ExpReset;
      lines_since_check = '0;
      startup_count     = '0;
      is_calibrated     = 1'b0;
      white_done        = 1'b0;
      white_level_q     = '0;
      expected_lines.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // result transfer against the oldest expected line
      if (res_i.valid && res_i.ready) begin
        if (expected_lines.size() == 0) begin
          $error("line result with no line end waiting");
          fail_count_o++;
        end else begin
          want = expected_lines.pop_front();
          check_field("exposure", want.exposure, res_i.exposure);
          check_field("calibrated", want.calibrated, res_i.calibrated);
          check_field("center_average", want.center_average, res_i.center_average);
          check_field("white_level", want.white_level, res_i.white_level);
          check_field("white_valid", want.white_valid, res_i.white_valid);
          check_field("edge_position", want.edge_position, res_i.edge_position);
        end
      end
      // register write transfer
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_idx_e'(cfg_i.index))
          CfgInitialExposure: reg_initial_exposure = cfg_i.data[ExpW-1:0];
          CfgTargetLow:       reg_target_low       = cfg_i.data[PixW-1:0];
          CfgTargetHigh:      reg_target_high      = cfg_i.data[PixW-1:0];
          CfgExposureMin:     reg_exposure_min     = cfg_i.data[ExpW-1:0];
          CfgExposureMax:     reg_exposure_max     = cfg_i.data[ExpW-1:0];
          CfgStartupFrames:   reg_startup_frames   = cfg_i.data[CntW-1:0];
          CfgCheckGap:        reg_check_gap        = cfg_i.data[CntW-1:0];
          default: ;
        endcase
      end
      // pixel transfer
      if (pix_i.valid && pix_i.ready) begin
        track_pixel(pix_i.sample, pix_i.line_end);
      end
      pending_o = expected_lines.size();
    end
  end

endmodule

// ===== test/line_camera_exposure_and_edge_level_test.sv =====
// testbench top: clock, reset, pixel and register stimulus, result stalls and verdict
// depends on lcel_pkg, lcel_intf, the block and line_camera_exposure_and_edge_level_check
module line_camera_exposure_and_edge_level_test;
  import lcel_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgUnused = 3'd7;
  localparam int MaxWait     = 13;
  localparam int DrainCycles = 4;
  localparam int HoldCycles  = 400;
  localparam int IdleLimit   = 3000;

  // line counts per phase; the long result stall lands early in the ramp-up phase
  localparam int OpeningLines = 6;
  localparam int StartLines   = 4;
  localparam int GapLines     = 4;
  localparam int DownLines    = 5;
  localparam int RampLines    = 85;
  localparam int QuietLines   = 4;
  localparam int SettleLines  = 12;
  localparam int HoldAfter    = OpeningLines + StartLines + GapLines + DownLines + 3;
  // startup count sits at 10 until the quiet phase, which adds one per line
  localparam int QuietCount   = 10 + QuietLines;

  // opening samples: bit 12 marks the line end
  localparam int OpeningLen = 17;
  localparam logic [12:0] Opening [OpeningLen] = '{
    13'h1FFF,
    13'h0000, 13'h1AAA,
    13'h0555, 13'h000F, 13'h1FF0,
    13'h1010,
    13'h07FF, 13'h0800, 13'h00F0, 13'h1F0F,
    13'h0FFF, 13'h0000, 13'h0FFF, 13'h0000, 13'h0FFF, 13'h1001
  };

  // pixel levels that give ties and both white level limits
  localparam logic [PixW-1:0] Levels [4] = '{8'd0, 8'd8, 8'd235, 8'd255};

  typedef enum logic [1:0] {LenTiny, LenCenter, LenMixed} len_mode_e;
  typedef enum logic [2:0] {CenterFree, CenterDark, CenterMid, CenterBright, CenterAny} center_e;
  typedef enum logic [1:0] {PixRandom, PixLevels, PixFalling, PixRising} pix_style_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   pending_lines;
  int   stall_cycles = 0;
  bit   sender_steady = 1'b0;

  lcel_in_if  pix_if ();
  lcel_cfg_if cfg_if ();
  lcel_out_if res_if ();

  line_camera_exposure_and_edge_level u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  line_camera_exposure_and_edge_level_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_i        (pix_if),
    .cfg_i        (cfg_if),
    .res_i        (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending_lines)
  );

  always #1 clk_i = ~clk_i;

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == IdleLimit) begin
      $display("[line_camera_exposure_and_edge_level] ERROR");
      $finish;
    end
  end

  // one pixel transfer after a random gap, or none while the sender is steady
  task automatic send_pixel(input logic [SampleW-1:0] sample, input logic last);
    int gap;
    gap = sender_steady ? 0 : $urandom_range(0, MaxWait);
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_if.valid    <= 1'b1;
    pix_if.sample   <= sample;
    pix_if.line_end <= last;
    @(posedge clk_i);
    while (!pix_if.ready) @(posedge clk_i);
  endtask

  // one register write transfer, channel lowered afterwards
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // stop offering pixels and wait for every line result
  task automatic settle();
    pix_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_lines != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // random lines with a chosen length profile and center brightness
  task automatic run_lines(input int count, input len_mode_e len_mode, input center_e center_kind);
    int              len;
    int              pick;
    center_e         center;
    pix_style_e      style;
    logic [PixW-1:0] pv;
    for (int n = 0; n < count; n++) begin
      sender_steady = ($urandom_range(0, 3) == 0);
      case (len_mode)
        LenTiny: len = $urandom_range(1, 4);
        LenCenter: begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(128, 150) : $urandom_range(66, 70);
        end
        default: begin
          pick = $urandom_range(0, 19);
          if (pick < 7) begin
            len = $urandom_range(1, 61);
          end else if (pick < 18) begin
            len = $urandom_range(62, 72);
          end else begin
            len = $urandom_range(120, 150);
          end
        end
      endcase
      center = (center_kind == CenterAny) ? center_e'($urandom_range(0, 3)) : center_kind;
      style  = pix_style_e'($urandom_range(0, 3));
      for (int i = 0; i < len; i++) begin
        case (style)
          PixLevels:  pv = Levels[$urandom_range(0, 3)];
          PixFalling: pv = (i < 85) ? 8'(255 - 3 * i) : 8'd0;
          PixRising:  pv = (i < 85) ? 8'(3 * i) : 8'd255;
          default:    pv = 8'($urandom_range(0, 255));
        endcase
        if (i >= CenterFirst && i <= CenterLast) begin
          case (center)
            CenterDark:   pv = 8'($urandom_range(0, 19));
            CenterMid:    pv = 8'($urandom_range(20, 200));
            CenterBright: pv = 8'($urandom_range(201, 255));
            default: ;
          endcase
        end
        send_pixel({pv, 4'($urandom_range(0, 15))}, i == len - 1);
      end
    end
  endtask

  // result side: random stalls, steady stretches and one long hold-off
  initial begin : result_sink
    int gap;
    int taken;
    bit steady;
    res_if.ready = 1'b0;
    taken  = 0;
    steady = 1'b0;
    @(posedge clk_i);
    forever begin
      if (taken % 20 == 0) begin
        steady = ($urandom_range(0, 2) == 0);
      end
      gap = steady ? 0 : $urandom_range(0, MaxWait);
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_if.valid) @(posedge clk_i);
      taken++;
      if (taken == HoldAfter) begin
        res_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
    end
  end

  initial begin : pixel_source
    pix_if.valid    = 1'b0;
    pix_if.sample   = '0;
    pix_if.line_end = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.data     = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // short lines with extreme samples at the reset settings, no exposure check yet
    for (int i = 0; i < OpeningLen; i++) begin
      send_pixel(Opening[i][SampleW-1:0], Opening[i][12]);
    end
    settle();

    // startup wait on short lines, then a check every third line pulling exposure down
    write_reg(CfgInitialExposure, 10'd1023);
    write_reg(CfgStartupFrames, 10'd10);
    write_reg(CfgCheckGap, 10'd2);
    write_reg(CfgExposureMin, 10'd246);
    write_reg(CfgExposureMax, 10'd1023);
    write_reg(CfgTargetLow, 10'd0);
    write_reg(CfgTargetHigh, 10'd100);
    run_lines(StartLines, LenTiny, CenterFree);
    run_lines(GapLines, LenCenter, CenterBright);
    settle();

    // check on every line, down to the lower bound and held there
    write_reg(CfgCheckGap, 10'd0);
    run_lines(DownLines, LenCenter, CenterBright);
    settle();

    // dark short lines ramp exposure up to its ceiling
    write_reg(CfgTargetLow, 10'h3FF);
    write_reg(CfgTargetHigh, 10'd255);
    write_reg(CfgExposureMin, 10'd1023);
    run_lines(RampLines, LenTiny, CenterFree);
    settle();

    // checks disabled: statistics only, startup count runs on
    write_reg(CfgStartupFrames, 10'd255);
    write_reg(CfgCheckGap, 10'd255);
    write_reg(CfgUnused, 10'($urandom_range(0, 1023)));
    write_reg(CfgInitialExposure, 10'd0);
    run_lines(QuietLines, LenMixed, CenterAny);
    settle();

    // exposure out of range or in band: calibration and white level
    write_reg(CfgStartupFrames, 10'(QuietCount));
    write_reg(CfgCheckGap, 10'd1);
    write_reg(CfgTargetLow, 10'd20);
    write_reg(CfgTargetHigh, 10'd200);
    write_reg(CfgExposureMin, 10'd0);
    write_reg(CfgExposureMax, 10'd0);
    run_lines(SettleLines, LenMixed, CenterAny);
    settle();

    if (fail_count == 0) begin
      $display("[line_camera_exposure_and_edge_level] OK");
    end else begin
      $display("[line_camera_exposure_and_edge_level] ERROR");
    end
    $finish;
  end

endmodule
